// ----- hw/rtl/pdm_pkg.sv -----
// Shared types and constants of the PWM period and duty meter.
package pdm_pkg;

  localparam int unsigned StampW    = 16;
  localparam int unsigned TimerHzW  = 24;
  localparam int unsigned DutyW     = 7;
  localparam int unsigned FreqW     = 16;

  localparam logic [TimerHzW-1:0] TimerHzReset = 24'd2000000;
  localparam logic [DutyW-1:0]    DutyMax      = 7'd100;
  localparam logic [FreqW-1:0]    FreqMax      = 16'hFFFF;

  // shared divider: 24-bit dividend, 16-bit divisor, two quotient bits a cycle
  localparam int unsigned DivW      = 24;
  localparam int unsigned DivRadix  = 2;
  localparam int unsigned DivSteps  = DivW / DivRadix;
  localparam int unsigned StepCntW  = $clog2(DivSteps);
  localparam logic [StepCntW-1:0] StepLast = StepCntW'(DivSteps - 1);
  localparam logic [DivW-1:0]     DutyScale = 24'd100;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [StampW-1:0] period;
    logic [StampW-1:0] high;
  } meas_t;

  typedef enum logic [1:0] {
    FR_WAIT_FIRST,
    FR_WAIT_FALL,
    FR_WAIT_RISE
  } fr_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DUTY,
    BK_FREQ,
    BK_OUT
  } bk_state_e;

endpackage

// ----- hw/rtl/pdm_front.sv -----
// Event classifier: tracks rise/fall sequence and queues finished measurements.
module pdm_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        pin_level_i,
  input  logic [pdm_pkg::StampW-1:0]  stamp_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output pdm_pkg::meas_t              push_data_o
);
  import pdm_pkg::*;

  fr_state_e         state_q, state_d;
  logic [StampW-1:0] rise_q, rise_d;
  logic [StampW-1:0] fall_q, fall_d;
  logic              accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign push_data_o.period = stamp_i - rise_q;
  assign push_data_o.high   = fall_q - rise_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_WAIT_FIRST;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rise_q <= rise_d;
    fall_q <= fall_d;
  end

  always_comb begin
    state_d = state_q;
    rise_d  = rise_q;
    fall_d  = fall_q;
    push_o  = 1'b0;
    unique case (state_q)
      FR_WAIT_FIRST: begin
        if (accept && pin_level_i) begin
          rise_d  = stamp_i;
          state_d = FR_WAIT_FALL;
        end
      end
      FR_WAIT_FALL: begin
        if (accept) begin
          if (pin_level_i) begin
            // second rise before any fall: drop the measurement
            state_d = FR_WAIT_FIRST;
          end else begin
            fall_d  = stamp_i;
            state_d = FR_WAIT_RISE;
          end
        end
      end
      FR_WAIT_RISE: begin
        if (accept && pin_level_i) begin
          push_o  = 1'b1;
          state_d = FR_WAIT_FIRST;
        end
      end
      default: state_d = FR_WAIT_FIRST;
    endcase
  end

endmodule

// ----- hw/rtl/pdm_queue.sv -----
// Short FIFO of finished measurements between front and back.
module pdm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pdm_pkg::meas_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output pdm_pkg::meas_t data_o
);
  import pdm_pkg::*;

  meas_t                entry_q [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueueAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueueAw'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueueAw'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !full_o)
    else $error("measurement pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("measurement popped from an empty queue");

endmodule

// ----- hw/rtl/pdm_back.sv -----
// Back end: timer_hz register, shared divider for duty and frequency, result register.
module pdm_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pdm_pkg::TimerHzW-1:0] cfg_timer_hz_i,
  input  logic                         q_valid_i,
  input  pdm_pkg::meas_t               q_data_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [pdm_pkg::StampW-1:0]   period_ticks_o,
  output logic [pdm_pkg::StampW-1:0]   high_ticks_o,
  output logic [pdm_pkg::DutyW-1:0]    duty_percent_o,
  output logic [pdm_pkg::FreqW-1:0]    frequency_hz_o,
  output logic                         zero_period_o
);
  import pdm_pkg::*;

  bk_state_e            state_q, state_d;
  logic [TimerHzW-1:0]  timer_hz_q;
  logic [StampW-1:0]    period_q, period_d;
  logic [StampW-1:0]    high_q, high_d;
  logic [DutyW-1:0]     duty_q, duty_d;
  logic [FreqW-1:0]     freq_q, freq_d;
  logic                 zero_q, zero_d;
  logic [DivW-1:0]      quo_q, quo_d;
  logic [StampW-1:0]    rem_q, rem_d;
  logic [StepCntW-1:0]  cnt_q, cnt_d;

  // two restoring steps per cycle
  logic [StampW:0]      r1, r2;
  logic [StampW-1:0]    ra, rb;
  logic                 b1, b2;
  logic [DivW-1:0]      quo_next;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    r1 = {rem_q, quo_q[DivW-1]};
    b1 = (r1 >= {1'b0, period_q});
    ra = b1 ? StampW'(r1 - {1'b0, period_q}) : r1[StampW-1:0];
    r2 = {ra, quo_q[DivW-2]};
    b2 = (r2 >= {1'b0, period_q});
    rb = b2 ? StampW'(r2 - {1'b0, period_q}) : r2[StampW-1:0];
    quo_next = {quo_q[DivW-3:0], b1, b2};
  end

  always_comb begin
    state_d  = state_q;
    period_d = period_q;
    high_d   = high_q;
    duty_d   = duty_q;
    freq_d   = freq_q;
    zero_d   = zero_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    pop_o    = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          pop_o    = 1'b1;
          period_d = q_data_i.period;
          high_d   = q_data_i.high;
          rem_d    = '0;
          cnt_d    = '0;
          quo_d    = DivW'(q_data_i.high) * DutyScale;
          if (q_data_i.period == '0) begin
            zero_d  = 1'b1;
            duty_d  = '0;
            freq_d  = '0;
            state_d = BK_OUT;
          end else begin
            zero_d  = 1'b0;
            state_d = BK_DUTY;
          end
        end
      end
      BK_DUTY: begin
        quo_d = quo_next;
        rem_d = rb;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == StepLast) begin
          duty_d  = (quo_next > DivW'(DutyMax)) ? DutyMax : quo_next[DutyW-1:0];
          quo_d   = DivW'(timer_hz_q);
          rem_d   = '0;
          cnt_d   = '0;
          state_d = BK_FREQ;
        end
      end
      BK_FREQ: begin
        quo_d = quo_next;
        rem_d = rb;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == StepLast) begin
          freq_d  = (quo_next[DivW-1:FreqW] != '0) ? FreqMax : quo_next[FreqW-1:0];
          cnt_d   = '0;
          state_d = BK_OUT;
        end
      end
      BK_OUT: begin
        if (out_ready_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      timer_hz_q <= TimerHzReset;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        timer_hz_q <= cfg_timer_hz_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    period_q <= period_d;
    high_q   <= high_d;
    duty_q   <= duty_d;
    freq_q   <= freq_d;
    zero_q   <= zero_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    cnt_q    <= cnt_d;
  end

  assign out_valid_o    = (state_q == BK_OUT);
  assign period_ticks_o = period_q;
  assign high_ticks_o   = high_q;
  assign duty_percent_o = duty_q;
  assign frequency_hz_o = freq_q;
  assign zero_period_o  = zero_q;

  a_zero_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_period_o |-> duty_percent_o == '0 && frequency_hz_o == '0)
    else $error("zero period with non-zero duty or frequency");

  a_duty_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duty_percent_o <= DutyMax)
    else $error("duty above cap");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == BK_DUTY || state_q == BK_OUT)
    else $error("pop did not start a measurement");

endmodule

// ----- hw/rtl/pwm_period_duty_meter.sv -----
// Top level of the PWM period and duty meter.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------------
//  in       | in_valid_i / in_ready_o  | pin_level_i, stamp_i
//  out      | out_valid_o / out_ready_i| period_ticks_o, high_ticks_o, duty_percent_o,
//           |                          | frequency_hz_o, zero_period_o
//  cfg      | cfg_valid_i / cfg_ready_o| cfg_timer_hz_i
//
// Pin events transfer one per cycle while the two-entry measurement queue has room.
// A closed measurement passes the back end in order: a load step, the shared divider
// for duty, then for frequency (two quotient bits a cycle), then the held result.
// A zero period skips the divider. out_ready_i low holds the result;
// in_ready_o drops only while the queue is full. Reset sets timer_hz to 2000000.
module pwm_period_duty_meter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         pin_level_i,
  input  logic [pdm_pkg::StampW-1:0]   stamp_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [pdm_pkg::StampW-1:0]   period_ticks_o,
  output logic [pdm_pkg::StampW-1:0]   high_ticks_o,
  output logic [pdm_pkg::DutyW-1:0]    duty_percent_o,
  output logic [pdm_pkg::FreqW-1:0]    frequency_hz_o,
  output logic                         zero_period_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pdm_pkg::TimerHzW-1:0] cfg_timer_hz_i
);
  import pdm_pkg::*;

  logic  push, full, pop, q_valid;
  meas_t push_data, q_data;

  pdm_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .pin_level_i,
    .stamp_i,
    .q_full_i    (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  pdm_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  pdm_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_timer_hz_i,
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o,
    .out_ready_i,
    .period_ticks_o,
    .high_ticks_o,
    .duty_percent_o,
    .frequency_hz_o,
    .zero_period_o
  );

endmodule
